### src/vmu_pkg.sv
// shared types, codes and helpers of the vector math unit
package vmu_pkg;

  localparam int W          = 32;
  localparam int FRAC       = 16;
  localparam int SQ_STAGES  = 32;  // one root bit per stage
  localparam int DIV_STAGES = 17;  // normalized quotient never exceeds 2^16
  localparam int QW         = 17;

  localparam logic [2:0] OP_DOT   = 3'd0;
  localparam logic [2:0] OP_ADD   = 3'd1;
  localparam logic [2:0] OP_SCALE = 3'd2;
  localparam logic [2:0] OP_CROSS = 3'd3;
  localparam logic [2:0] OP_MAG   = 3'd4;
  localparam logic [2:0] OP_NORM  = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] scale_factor;
  } vmu_in_t;

  typedef struct packed {
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic signed [31:0] r_scalar;
    logic [1:0]         status;
  } vmu_out_t;

  // what rides down the root and divide pipes next to the datapath
  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic signed [31:0] r_scalar;
    logic [1:0]         status;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
  } vmu_side_t;

  // {flag, value} clamped to the signed 32-bit range
  function automatic logic [32:0] sat32(input logic signed [65:0] v);
    logic [32:0] res;
    if (v > 66'sd2147483647) begin
      res = {1'b1, 32'h7fff_ffff};
    end else if (v < -66'sd2147483648) begin
      res = {1'b1, 32'h8000_0000};
    end else begin
      res = {1'b0, v[31:0]};
    end
    return res;
  endfunction

endpackage

### src/vector3_math_unit.sv
// top level of the Q16.16 three-component vector math unit
//
// usage
// - a request is taken on every rising edge with start high and busy low;
//   busy is low whenever the unit is out of reset, so a request can be
//   issued every cycle
// - in_req carries the opcode, vectors a and b and the scale factor
// - every request yields exactly one result on out_res, held for one cycle
//   and marked by out_strobe; results come back in request order
// - every opcode takes the same path: 3 front stages (operand select,
//   multiply, reduce/saturate), 32 square root stages (one root bit each),
//   17 divide stages (one quotient bit each) and one output register
// - throughput is one request per cycle; the deepest parts are the root
//   and divide pipes, every stage of which holds one request
// - reset clears all valid bits, so nothing in flight comes out; busy is
//   high while reset is applied
// - the receiver has no way to stall, so the pipe never holds
module vector3_math_unit import vmu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  vmu_in_t  in_req,
  output logic     out_strobe,
  output vmu_out_t out_res
);

  logic          take;
  logic          fr_vld;
  vmu_side_t     fr_side;
  logic [63:0]   fr_rad;
  logic          sq_vld;
  vmu_side_t     sq_side;
  logic [31:0]   sq_root;
  logic          dv_vld;
  vmu_side_t     dv_side;
  logic [31:0]   dv_root;
  logic [QW-1:0] dv_quo [0:2];

  logic          out_strobe_r;
  vmu_out_t      out_res_r;
  vmu_out_t      out_res_nxt;

  // nothing ever backs up, so only reset holds requests off
  assign busy = ~rst_n;
  assign take = start & ~busy;

  // products, sums and saturation for dot, add, scale and cross;
  // sum of squares for magnitude and normalize
  vmu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (take),
    .in_req   (in_req),
    .out_vld  (fr_vld),
    .out_side (fr_side),
    .out_rad  (fr_rad)
  );

  // floor square root of the Q32.32 sum of squares gives the Q16.16 length
  vmu_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (fr_vld),
    .in_side  (fr_side),
    .in_rad   (fr_rad),
    .out_vld  (sq_vld),
    .out_side (sq_side),
    .out_root (sq_root)
  );

  // (|c| << 16) / length for each component
  vmu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (sq_vld),
    .in_side  (sq_side),
    .in_root  (sq_root),
    .out_vld  (dv_vld),
    .out_side (dv_side),
    .out_root (dv_root),
    .out_quo  (dv_quo)
  );

  // final pick: magnitude and normalize finish here, the rest pass through
  always_comb begin
    logic [31:0] q [0:2];
    for (int l = 0; l < 3; l++) begin
      q[l] = 32'(dv_quo[l]);
    end
    out_res_nxt.r_x      = dv_side.r_x;
    out_res_nxt.r_y      = dv_side.r_y;
    out_res_nxt.r_z      = dv_side.r_z;
    out_res_nxt.r_scalar = dv_side.r_scalar;
    out_res_nxt.status   = dv_side.status;
    case (dv_side.req_type)
      OP_MAG: begin
        // length above the positive range clamps
        if (dv_root[31]) begin
          out_res_nxt.r_scalar = 32'h7fff_ffff;
          out_res_nxt.status   = ST_SAT;
        end else begin
          out_res_nxt.r_scalar = dv_root;
          out_res_nxt.status   = ST_OK;
        end
      end
      OP_NORM: begin
        out_res_nxt.r_scalar = '0;
        if (dv_root == 32'd0) begin
          // zero-length vector
          out_res_nxt.r_x    = '0;
          out_res_nxt.r_y    = '0;
          out_res_nxt.r_z    = '0;
          out_res_nxt.status = ST_ZERO;
        end else begin
          out_res_nxt.r_x    = dv_side.a_x[31] ? (~q[0] + 32'd1) : q[0];
          out_res_nxt.r_y    = dv_side.a_y[31] ? (~q[1] + 32'd1) : q[1];
          out_res_nxt.r_z    = dv_side.a_z[31] ? (~q[2] + 32'd1) : q[2];
          out_res_nxt.status = ST_OK;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= dv_vld;
    end
    out_res_r <= out_res_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

endmodule

### src/vmu_front.sv
// front end: operand select, six multipliers, reduce and saturate
module vmu_front import vmu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  vmu_in_t     in_req,
  output logic        out_vld,
  output vmu_side_t   out_side,
  output logic [63:0] out_rad
);

  logic               a_vld_r;
  vmu_in_t            a_req_r;
  logic               b_vld_r;
  vmu_in_t            b_req_r;
  logic signed [63:0] prod_r [0:5];
  logic               c_vld_r;
  vmu_side_t          c_side_r;
  logic [63:0]        c_rad_r;

  logic signed [31:0] mul_x [0:5];
  logic signed [31:0] mul_y [0:5];
  logic signed [63:0] prod_nxt [0:5];
  vmu_side_t          c_side_nxt;
  logic [63:0]        c_rad_nxt;

  // lanes 3..5 only serve the cross product
  always_comb begin
    mul_x[0] = a_req_r.a_x;
    mul_x[1] = a_req_r.a_y;
    mul_x[2] = a_req_r.a_z;
    mul_y[0] = a_req_r.b_x;
    mul_y[1] = a_req_r.b_y;
    mul_y[2] = a_req_r.b_z;
    mul_x[3] = a_req_r.a_z;
    mul_y[3] = a_req_r.b_y;
    mul_x[4] = a_req_r.a_x;
    mul_y[4] = a_req_r.b_z;
    mul_x[5] = a_req_r.a_y;
    mul_y[5] = a_req_r.b_x;
    case (a_req_r.req_type) inside
      OP_SCALE: begin
        mul_y[0] = a_req_r.scale_factor;
        mul_y[1] = a_req_r.scale_factor;
        mul_y[2] = a_req_r.scale_factor;
      end
      OP_MAG, OP_NORM: begin
        mul_y[0] = a_req_r.a_x;
        mul_y[1] = a_req_r.a_y;
        mul_y[2] = a_req_r.a_z;
      end
      OP_CROSS: begin
        mul_x[0] = a_req_r.a_y;
        mul_y[0] = a_req_r.b_z;
        mul_x[1] = a_req_r.a_z;
        mul_y[1] = a_req_r.b_x;
        mul_x[2] = a_req_r.a_x;
        mul_y[2] = a_req_r.b_y;
      end
      default: begin
      end
    endcase
    for (int i = 0; i < 6; i++) begin
      prod_nxt[i] = mul_x[i] * mul_y[i];
    end
  end

  always_comb begin
    logic signed [65:0] p66 [0:5];
    logic signed [65:0] sum3;
    logic signed [65:0] v [0:3];
    logic [32:0]        s [0:3];
    for (int i = 0; i < 6; i++) begin
      p66[i] = 66'(prod_r[i]);
    end
    sum3 = p66[0] + p66[1] + p66[2];
    for (int i = 0; i < 4; i++) begin
      v[i] = '0;
    end
    case (b_req_r.req_type)
      OP_DOT: v[3] = sum3 >>> FRAC;
      OP_ADD: begin
        v[0] = 66'(b_req_r.a_x) + 66'(b_req_r.b_x);
        v[1] = 66'(b_req_r.a_y) + 66'(b_req_r.b_y);
        v[2] = 66'(b_req_r.a_z) + 66'(b_req_r.b_z);
      end
      OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          v[i] = p66[i] >>> FRAC;
        end
      end
      OP_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          v[i] = (p66[i] - p66[i+3]) >>> FRAC;
        end
      end
      default: begin
      end
    endcase
    for (int i = 0; i < 4; i++) begin
      s[i] = sat32(v[i]);
    end
    c_side_nxt.req_type = b_req_r.req_type;
    c_side_nxt.r_x      = s[0][31:0];
    c_side_nxt.r_y      = s[1][31:0];
    c_side_nxt.r_z      = s[2][31:0];
    c_side_nxt.r_scalar = s[3][31:0];
    c_side_nxt.status   = (s[0][32] | s[1][32] | s[2][32] | s[3][32]) ? ST_SAT : ST_OK;
    c_side_nxt.a_x      = b_req_r.a_x;
    c_side_nxt.a_y      = b_req_r.a_y;
    c_side_nxt.a_z      = b_req_r.a_z;
    // sum of three squares stays below 2^64
    c_rad_nxt           = sum3[63:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_vld;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
    end
    a_req_r  <= in_req;
    b_req_r  <= a_req_r;
    for (int i = 0; i < 6; i++) begin
      prod_r[i] <= prod_nxt[i];
    end
    c_side_r <= c_side_nxt;
    c_rad_r  <= c_rad_nxt;
  end

  assign out_vld  = c_vld_r;
  assign out_side = c_side_r;
  assign out_rad  = c_rad_r;

endmodule

### src/vmu_sqrt.sv
// pipelined integer square root, one root bit per stage
module vmu_sqrt import vmu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  vmu_side_t   in_side,
  input  logic [63:0] in_rad,
  output logic        out_vld,
  output vmu_side_t   out_side,
  output logic [31:0] out_root
);

  localparam int N = SQ_STAGES;

  logic        vld_r  [0:N-1];
  vmu_side_t   side_r [0:N-1];
  logic [63:0] rad_r  [0:N-1];
  logic [33:0] rem_r  [0:N-1];
  logic [31:0] root_r [0:N-1];

  logic [63:0] rad_nxt  [0:N-1];
  logic [33:0] rem_nxt  [0:N-1];
  logic [31:0] root_nxt [0:N-1];

  always_comb begin
    logic [63:0] src_rad;
    logic [33:0] src_rem;
    logic [31:0] src_root;
    logic [35:0] remsh;
    logic [35:0] trial;
    logic        ge;
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        src_rad  = in_rad;
        src_rem  = '0;
        src_root = '0;
      end else begin
        src_rad  = rad_r[k-1];
        src_rem  = rem_r[k-1];
        src_root = root_r[k-1];
      end
      remsh       = {src_rem, src_rad[63:62]};
      trial       = {2'b00, src_root, 2'b01};
      ge          = (remsh >= trial);
      rem_nxt[k]  = ge ? 34'(remsh - trial) : remsh[33:0];
      root_nxt[k] = {src_root[30:0], ge};
      rad_nxt[k]  = {src_rad[61:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < N; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else begin
      vld_r[0] <= in_vld;
      for (int k = 1; k < N; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
    side_r[0] <= in_side;
    for (int k = 1; k < N; k++) begin
      side_r[k] <= side_r[k-1];
    end
    for (int k = 0; k < N; k++) begin
      rad_r[k]  <= rad_nxt[k];
      rem_r[k]  <= rem_nxt[k];
      root_r[k] <= root_nxt[k];
    end
  end

  assign out_vld  = vld_r[N-1];
  assign out_side = side_r[N-1];
  assign out_root = root_r[N-1];

endmodule

### src/vmu_div.sv
// three-lane pipelined restoring divider for normalize
module vmu_div import vmu_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  input  vmu_side_t     in_side,
  input  logic [31:0]   in_root,
  output logic          out_vld,
  output vmu_side_t     out_side,
  output logic [31:0]   out_root,
  output logic [QW-1:0] out_quo [0:2]
);

  localparam int N = DIV_STAGES;

  logic          vld_r  [0:N-1];
  vmu_side_t     side_r [0:N-1];
  logic [31:0]   root_r [0:N-1];
  logic [31:0]   rem_r  [0:N-1][0:2];
  logic [QW-1:0] num_r  [0:N-1][0:2];
  logic [QW-1:0] quo_r  [0:N-1][0:2];

  logic [31:0]   rem_nxt [0:N-1][0:2];
  logic [QW-1:0] num_nxt [0:N-1][0:2];
  logic [QW-1:0] quo_nxt [0:N-1][0:2];

  always_comb begin
    logic signed [31:0] a_in [0:2];
    logic [31:0]        mag;
    logic [31:0]        src_rem;
    logic [QW-1:0]      src_num;
    logic [QW-1:0]      src_quo;
    logic [31:0]        src_root;
    logic [32:0]        remsh;
    logic               ge;
    a_in[0] = in_side.a_x;
    a_in[1] = in_side.a_y;
    a_in[2] = in_side.a_z;
    for (int k = 0; k < N; k++) begin
      for (int l = 0; l < 3; l++) begin
        if (k == 0) begin
          // numerator is |a| << 16; its top bits seed the remainder
          mag      = a_in[l][31] ? (~a_in[l] + 32'd1) : a_in[l];
          src_rem  = {1'b0, mag[31:1]};
          src_num  = {mag[0], {(QW-1){1'b0}}};
          src_quo  = '0;
          src_root = in_root;
        end else begin
          mag      = '0;
          src_rem  = rem_r[k-1][l];
          src_num  = num_r[k-1][l];
          src_quo  = quo_r[k-1][l];
          src_root = root_r[k-1];
        end
        remsh         = {src_rem, src_num[QW-1]};
        ge            = (remsh >= {1'b0, src_root});
        rem_nxt[k][l] = ge ? 32'(remsh - {1'b0, src_root}) : remsh[31:0];
        num_nxt[k][l] = {src_num[QW-2:0], 1'b0};
        quo_nxt[k][l] = {src_quo[QW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < N; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else begin
      vld_r[0] <= in_vld;
      for (int k = 1; k < N; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
    side_r[0] <= in_side;
    root_r[0] <= in_root;
    for (int k = 1; k < N; k++) begin
      side_r[k] <= side_r[k-1];
      root_r[k] <= root_r[k-1];
    end
    for (int k = 0; k < N; k++) begin
      for (int l = 0; l < 3; l++) begin
        rem_r[k][l] <= rem_nxt[k][l];
        num_r[k][l] <= num_nxt[k][l];
        quo_r[k][l] <= quo_nxt[k][l];
      end
    end
  end

  assign out_vld  = vld_r[N-1];
  assign out_side = side_r[N-1];
  assign out_root = root_r[N-1];
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      out_quo[l] = quo_r[N-1][l];
    end
  end

endmodule
